### sv/bal_pkg.sv
// bal_pkg: shared types and constants for the bounded array list.
// Used by bal_cell and bounded_array_list. No dependencies.
package bal_pkg;

  // Default sizing
  localparam int CAPACITY      = 16;
  localparam int ELEMENT_WIDTH = 32;

  // Fixed field widths of the channels
  localparam int MODE_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int COUNT_W = 5;

  // Operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_INS_POS  = 3'd0,
    MODE_REM_POS  = 3'd1,
    MODE_INS_SORT = 3'd2,
    MODE_REM_VAL  = 3'd3,
    MODE_CLEAR    = 3'd4
  } mode_t;

  // Control sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_t;

  // Input item
  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic                      ok;
    logic signed [VALUE_W-1:0] removed_value;
    logic [COUNT_W-1:0]        count;
  } out_item_t;

  // Per-cell update command
  typedef struct packed {
    logic load;        // take the new value
    logic take_left;   // take the left neighbor's element (insert shift)
    logic take_right;  // take the right neighbor's element (remove shift)
  } cell_op_t;

endpackage

### sv/bal_cell.sv
// bal_cell: one storage cell of the list chain, holding one element and
// its registered compare flags. Depends on bal_pkg.
module bal_cell #(
  parameter int ELEMENT_WIDTH = bal_pkg::ELEMENT_WIDTH
) (
  input  logic                            clk,
  input  logic                            cmp_en,
  input  logic signed [ELEMENT_WIDTH-1:0] value,
  input  bal_pkg::cell_op_t               op,
  input  logic signed [ELEMENT_WIDTH-1:0] left_elem,
  input  logic signed [ELEMENT_WIDTH-1:0] right_elem,
  output logic signed [ELEMENT_WIDTH-1:0] elem,
  output logic                            gt,
  output logic                            eq
);

  logic signed [ELEMENT_WIDTH-1:0] elem_r, elem_nxt;
  logic                            gt_r, gt_nxt;
  logic                            eq_r, eq_nxt;

  // Compare against the incoming value; pick the new element
  always_comb begin
    gt_nxt = gt_r;
    eq_nxt = eq_r;
    if (cmp_en) begin
      gt_nxt = elem_r > value;
      eq_nxt = elem_r == value;
    end
    elem_nxt = elem_r;
    if (op.load) begin
      elem_nxt = value;
    end else if (op.take_left) begin
      elem_nxt = left_elem;
    end else if (op.take_right) begin
      elem_nxt = right_elem;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
    gt_r   <= gt_nxt;
    eq_r   <= eq_nxt;
  end

  assign elem = elem_r;
  assign gt   = gt_r;
  assign eq   = eq_r;

endmodule

### sv/bal_scan.sv
// bal_scan: parallel-prefix OR across the cell row; bit i of the result is
// set when any request at or left of cell i is set. Depends on nothing.
module bal_scan #(
  parameter int WIDTH = 16
) (
  input  logic [WIDTH-1:0] req,
  output logic [WIDTH-1:0] thr
);

  localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] lvl [0:LEVELS];

  assign lvl[0] = req;

  // Log-depth prefix network
  for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
    for (genvar i = 0; i < WIDTH; i++) begin : g_bit
      if (i >= (1 << k)) begin : g_or
        assign lvl[k+1][i] = lvl[k][i] | lvl[k][i-(1<<k)];
      end else begin : g_pass
        assign lvl[k+1][i] = lvl[k][i];
      end
    end
  end

  assign thr = lvl[LEVELS];

endmodule

### sv/bounded_array_list.sv
// bounded_array_list: fixed-capacity ordered list built as a row of cells.
// Depends on bal_pkg, bal_cell and bal_scan.
//
//   channel | ports                        | payload
//   input   | in_valid, in_ready, in_data  | bal_pkg::in_item_t
//   result  | out_valid, out_ready, out_data | bal_pkg::out_item_t
//
// Each operation has a transfer cycle, where every cell compares its
// element with the value, then an apply cycle, where the prefix scan
// places the edge and every cell shifts, loads or holds.
// Synchronous active-low reset empties the list and drops any result.
// A waiting result does not block a new transfer; the apply cycle waits
// while the output register is still full.
module bounded_array_list #(
  parameter int CAPACITY      = bal_pkg::CAPACITY,
  parameter int ELEMENT_WIDTH = bal_pkg::ELEMENT_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bal_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bal_pkg::out_item_t  out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > bal_pkg::POS_W) ? CNT_W : bal_pkg::POS_W;

  // Control state
  bal_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic out_valid_r, out_valid_nxt;
  bal_pkg::out_item_t out_data_r, out_data_nxt;

  // Latched operation
  logic [bal_pkg::MODE_W-1:0]       op_mode_r, op_mode_nxt;
  logic signed [ELEMENT_WIDTH-1:0]  op_value_r, op_value_nxt;
  logic [bal_pkg::POS_W-1:0]        op_pos_r, op_pos_nxt;

  // Cell row
  logic signed [ELEMENT_WIDTH-1:0] elem [CAPACITY];
  logic [CAPACITY-1:0] gt, eq, req, thr, thr_prev, valid;
  bal_pkg::cell_op_t   cell_op [CAPACITY];
  logic signed [ELEMENT_WIDTH-1:0] cell_value;

  logic accept, slot_free, commit, ok, is_ins, is_rem;
  logic [CMP_W-1:0] pos_c, cnt_c;
  logic signed [ELEMENT_WIDTH-1:0] removed_e;

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state_r == bal_pkg::ST_IDLE);
  assign slot_free  = !out_valid_r || out_ready;
  assign pos_c      = CMP_W'(op_pos_r);
  assign cnt_c      = CMP_W'(count_r);
  // Compare against the incoming value at transfer; load the latched one
  assign cell_value = accept ? ELEMENT_WIDTH'(in_data.value) : op_value_r;

  // Per-cell edge requests
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i] = CMP_W'(i) < cnt_c;
      case (op_mode_r)
        bal_pkg::MODE_INS_SORT: req[i] = gt[i] || !valid[i];
        bal_pkg::MODE_REM_VAL:  req[i] = eq[i] && valid[i];
        default:                req[i] = (CMP_W'(i) == pos_c);
      endcase
    end
  end

  bal_scan #(
    .WIDTH (CAPACITY)
  ) u_scan (
    .req (req),
    .thr (thr)
  );

  assign thr_prev = {thr[CAPACITY-2:0], 1'b0};

  // Outcome of the latched operation
  always_comb begin
    ok     = 1'b0;
    is_ins = 1'b0;
    is_rem = 1'b0;
    case (op_mode_r)
      bal_pkg::MODE_INS_POS: begin
        is_ins = 1'b1;
        ok     = (cnt_c < CMP_W'(CAPACITY)) && (pos_c <= cnt_c);
      end
      bal_pkg::MODE_REM_POS: begin
        is_rem = 1'b1;
        ok     = pos_c < cnt_c;
      end
      bal_pkg::MODE_INS_SORT: begin
        is_ins = 1'b1;
        ok     = cnt_c < CMP_W'(CAPACITY);
      end
      bal_pkg::MODE_REM_VAL: begin
        is_rem = 1'b1;
        ok     = |req;
      end
      bal_pkg::MODE_CLEAR: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign commit = (state_r == bal_pkg::ST_APPLY) && slot_free && ok;

  // Cell commands
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_op[i].load       = commit && is_ins && thr[i] && !thr_prev[i];
      cell_op[i].take_left  = commit && is_ins && thr_prev[i];
      cell_op[i].take_right = commit && is_rem && thr[i];
    end
  end

  // Element picked by remove at position (one-hot select)
  always_comb begin
    removed_e = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (req[i]) begin
        removed_e = removed_e | elem[i];
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bal_cell #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_cell (
      .clk        (clk),
      .cmp_en     (accept),
      .value      (cell_value),
      .op         (cell_op[i]),
      .left_elem  (elem[(i > 0) ? i - 1 : i]),
      .right_elem (elem[(i < CAPACITY - 1) ? i + 1 : i]),
      .elem       (elem[i]),
      .gt         (gt[i]),
      .eq         (eq[i])
    );
  end

  // Sequencer: next state, count and result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    op_mode_nxt   = op_mode_r;
    op_value_nxt  = op_value_r;
    op_pos_nxt    = op_pos_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      bal_pkg::ST_IDLE: begin
        if (accept) begin
          op_mode_nxt  = in_data.mode;
          op_value_nxt = ELEMENT_WIDTH'(in_data.value);
          op_pos_nxt   = in_data.position;
          state_nxt    = bal_pkg::ST_APPLY;
        end
      end
      bal_pkg::ST_APPLY: begin
        if (slot_free) begin
          if (commit) begin
            if (is_ins) begin
              count_nxt = count_r + CNT_W'(1);
            end else if (is_rem) begin
              count_nxt = count_r - CNT_W'(1);
            end else begin
              count_nxt = '0;
            end
          end
          out_valid_nxt         = 1'b1;
          out_data_nxt.ok       = ok;
          out_data_nxt.removed_value =
            (ok && op_mode_r == bal_pkg::MODE_REM_POS) ? bal_pkg::VALUE_W'(removed_e) : '0;
          out_data_nxt.count    = bal_pkg::COUNT_W'(commit ? count_nxt : count_r);
          state_nxt             = bal_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bal_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bal_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    op_mode_r  <= op_mode_nxt;
    op_value_r <= op_value_nxt;
    op_pos_r   <= op_pos_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
